// ===== design/bta_pkg.sv =====
package bta_pkg;

  localparam int unsigned HEAP_BYTES        = 4096;
  localparam int unsigned TAG_BYTES         = 4;
  localparam int unsigned MIN_SPLIT_PAYLOAD = 16;

  localparam int unsigned OFF_W   = 13;              // byte offset up to HEAP_BYTES
  localparam int unsigned TAG_W   = 12;              // stored tag width
  localparam int unsigned SIZE_W  = 14;              // rounded request size
  localparam int unsigned DEPTH   = HEAP_BYTES / 2;  // one tag per 2-byte word
  localparam int unsigned IDX_W   = $clog2(DEPTH);

  localparam logic [OFF_W-1:0] OVERHEAD  = OFF_W'(2 * TAG_BYTES);
  localparam logic [OFF_W-1:0] TAG_OFF   = OFF_W'(TAG_BYTES);
  localparam logic [OFF_W-1:0] LIMIT_MAX = OFF_W'(HEAP_BYTES);
  localparam logic [SIZE_W-1:0] SPLIT_MIN = SIZE_W'(2 * TAG_BYTES + MIN_SPLIT_PAYLOAD);

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } command_e;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_FREED     = 2'd2,
    ST_IGNORED   = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_READ_H,
    OP_NEXT,
    OP_SPLIT_W1,
    OP_SPLIT_W2,
    OP_SPLIT_W3,
    OP_SPLIT_W4,
    OP_USE_W,
    OP_APP_W1,
    OP_APP_W2,
    OP_READ_TGT,
    OP_FREE_W,
    OP_JN_W1,
    OP_JN_W2,
    OP_READ_PF,
    OP_READ_PREV,
    OP_JP_W1,
    OP_JP_W2
  } op_e;

  typedef struct packed {
    op_e     op;
    logic    res_load;
    status_e res_code;
  } cmd_t;

  typedef struct packed {
    logic is_free_cmd;
    logic size_zero;
    logic addr_low;
    logic tgt_zero;
    logic h_ge_brk;
    logic h_eq_brk;
    logic h_eq_tgt;
    logic h_gt_tgt;
    logic rd_free;
    logic fit;
    logic can_split;
    logic app_ok;
  } sts_t;

endpackage

// ===== design/boundary_tag_first_fit_allocator_unit.sv =====
// First-fit heap allocator with boundary tags over a 4 KB heap. Each transaction on the slave
// side is one request: allocate (tuser 0) a payload of request_size bytes, rounded up to even,
// or free (tuser 1) the block whose payload starts at block_address. One transaction per request
// leaves on the master side with the payload offset and a status code. Only one request is in
// work at a time; tready is high while the unit is idle. An allocate walks the block chain from
// offset 0, reading one header tag per block through the single-port tag memory; a free walks
// the chain up to its block in the same way and then merges it with a free next or previous
// block. A finished result is held in an output register, so the next request can be taken
// once the result has been handed over or is waiting there. The heap_limit register is written
// through the configuration channel (always ready) and must only be written while the unit is
// idle; values above 4096 act as 4096.
module boundary_tag_first_fit_allocator_unit import bta_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [12:0] request_size, [24:13] block_address, zero above
  input  logic        s_axis_tuser,   // [0] command
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [11:0] result_address, zero above
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  // heap_limit write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [12:0] cfg_data_i
);

  cmd_t             cmd;
  sts_t             sts;
  logic [TAG_W-1:0] res_addr;
  logic [1:0]       res_status;

  // The controller sequences tag reads and writes; the datapath holds the tag memory,
  // the walk pointer, the break pointer and the limit.
  bta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bta_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_command_i (s_axis_tuser),
    .in_size_i    (s_axis_tdata[12:0]),
    .in_addr_i    (s_axis_tdata[24:13]),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .res_addr_o   (res_addr),
    .res_status_o (res_status)
  );

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {4'b0000, res_addr};
  assign m_axis_tuser = res_status;

endmodule

// ===== design/bta_dp.sv =====
module bta_dp import bta_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic                in_command_i,
  input  logic [OFF_W-1:0]    in_size_i,
  input  logic [TAG_W-1:0]    in_addr_i,
  input  logic                cfg_we_i,
  input  logic [OFF_W-1:0]    cfg_data_i,
  output logic [TAG_W-1:0]    res_addr_o,
  output logic [1:0]          res_status_o
);

  logic [TAG_W-1:0]  mem [DEPTH];
  logic [TAG_W-1:0]  rdata_q;
  logic [OFF_W-1:0]  h_q, brk_q, lim_q;
  logic [SIZE_W-1:0] sz_q;
  logic [TAG_W-1:0]  tgt_q, pc_q, prev_q;
  logic              cmd_q, zero_q, low_q;
  logic [TAG_W-1:0]  res_addr_q;
  logic [1:0]        res_status_q;

  logic [TAG_W-1:0]  p;
  logic [OFF_W-1:0]  p_off, sz_off, tgt_off, pc_off, prev_off, nx, lim_eff;
  logic [SIZE_W-1:0] size_inc;
  logic [OFF_W+1:0]  app_sum;
  logic [TAG_W-1:0]  rem, merged;
  logic              we, re;
  logic [OFF_W-1:0]  wa, ra;
  logic [TAG_W-1:0]  wd;

  assign p        = {rdata_q[TAG_W-1:1], 1'b0};
  assign p_off    = {1'b0, p};
  assign sz_off   = sz_q[OFF_W-1:0];
  assign tgt_off  = {1'b0, tgt_q};
  assign pc_off   = {1'b0, pc_q};
  assign prev_off = {1'b0, prev_q};
  assign nx       = h_q + p_off + OVERHEAD;
  assign lim_eff  = (lim_q > LIMIT_MAX) ? LIMIT_MAX : lim_q;
  assign size_inc = {1'b0, in_size_i} + SIZE_W'(1);
  assign app_sum  = {2'b00, brk_q} + {1'b0, sz_q} + {2'b00, OVERHEAD};
  assign rem      = p - sz_q[TAG_W-1:0] - OVERHEAD[TAG_W-1:0];
  assign merged   = p + pc_q + OVERHEAD[TAG_W-1:0];

  always_comb begin
    sts_o.is_free_cmd = (cmd_q == CMD_FREE);
    sts_o.size_zero   = zero_q;
    sts_o.addr_low    = low_q;
    sts_o.tgt_zero    = (tgt_q == '0);
    sts_o.h_ge_brk    = (h_q >= brk_q);
    sts_o.h_eq_brk    = (h_q == brk_q);
    sts_o.h_eq_tgt    = (h_q == tgt_off);
    sts_o.h_gt_tgt    = (h_q > tgt_off);
    sts_o.rd_free     = rdata_q[0];
    sts_o.fit         = rdata_q[0] && ({2'b00, p} >= sz_q);
    sts_o.can_split   = (({2'b00, p} - sz_q) >= SPLIT_MIN);
    sts_o.app_ok      = (app_sum <= {2'b00, lim_eff});
  end

  // Memory port selection per datapath operation.
  always_comb begin
    we = 1'b0;
    re = 1'b0;
    wa = h_q;
    ra = h_q;
    wd = '0;
    unique case (cmd_i.op)
      OP_READ_H:    re = 1'b1;
      OP_READ_TGT:  begin re = 1'b1; ra = tgt_off; end
      OP_READ_PF:   begin re = 1'b1; ra = tgt_off - TAG_OFF; end
      OP_READ_PREV: begin re = 1'b1; ra = {1'b0, rdata_q}; end
      OP_SPLIT_W1:  begin we = 1'b1; wd = sz_q[TAG_W-1:0]; end
      OP_SPLIT_W2:  begin we = 1'b1; wa = h_q + TAG_OFF + sz_off; wd = h_q[TAG_W-1:0]; end
      OP_SPLIT_W3:  begin
        we = 1'b1; wa = h_q + sz_off + OVERHEAD; wd = {rem[TAG_W-1:1], 1'b1};
      end
      OP_SPLIT_W4:  begin
        we = 1'b1; wa = h_q + p_off + TAG_OFF;
        wd = h_q[TAG_W-1:0] + sz_q[TAG_W-1:0] + OVERHEAD[TAG_W-1:0];
      end
      OP_USE_W:     begin we = 1'b1; wd = p; end
      OP_APP_W1:    begin we = 1'b1; wa = brk_q; wd = sz_q[TAG_W-1:0]; end
      OP_APP_W2:    begin we = 1'b1; wa = h_q + TAG_OFF + sz_off; wd = h_q[TAG_W-1:0]; end
      OP_FREE_W:    begin we = 1'b1; wa = tgt_off; wd = {p[TAG_W-1:1], 1'b1}; end
      OP_JN_W1:     begin we = 1'b1; wa = tgt_off; wd = {merged[TAG_W-1:1], 1'b1}; end
      OP_JN_W2:     begin we = 1'b1; wa = tgt_off + TAG_OFF + pc_off; wd = tgt_q; end
      OP_JP_W1:     begin we = 1'b1; wa = prev_off; wd = {merged[TAG_W-1:1], 1'b1}; end
      OP_JP_W2:     begin we = 1'b1; wa = prev_off + TAG_OFF + pc_off; wd = prev_q; end
      default:      ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa[IDX_W:1]] <= wd;
    end
    if (re) begin
      rdata_q <= mem[ra[IDX_W:1]];
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        sz_q   <= {size_inc[SIZE_W-1:1], 1'b0};
        tgt_q  <= in_addr_i - TAG_W'(TAG_BYTES);
        cmd_q  <= in_command_i;
        zero_q <= (in_size_i == '0);
        low_q  <= (in_addr_i < TAG_W'(TAG_BYTES));
        h_q    <= '0;
      end
      OP_NEXT:      h_q <= nx;
      OP_APP_W1:    h_q <= brk_q;
      OP_FREE_W: begin
        pc_q <= p;
        h_q  <= tgt_off + p_off + OVERHEAD;
      end
      OP_JN_W1:     pc_q <= merged;
      OP_READ_PREV: prev_q <= rdata_q;
      OP_JP_W1:     pc_q <= merged;
      default:      ;
    endcase
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_code;
      res_addr_q   <= (cmd_i.res_code == ST_ALLOCATED) ?
                      h_q[TAG_W-1:0] + TAG_W'(TAG_BYTES) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brk_q <= '0;
      lim_q <= LIMIT_MAX;
    end else begin
      if (cmd_i.op == OP_APP_W2) begin
        brk_q <= h_q + sz_off + OVERHEAD;
      end
      if (cfg_we_i) begin
        lim_q <= cfg_data_i;
      end
    end
  end

  assign res_addr_o   = res_addr_q;
  assign res_status_o = res_status_q;

endmodule

// ===== design/bta_ctrl.sv =====
module bta_ctrl import bta_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [26:0] {
    S_IDLE     = 27'd1 << 0,
    S_DECIDE   = 27'd1 << 1,
    S_SCAN     = 27'd1 << 2,
    S_SCAN_CHK = 27'd1 << 3,
    S_SPLIT1   = 27'd1 << 4,
    S_SPLIT2   = 27'd1 << 5,
    S_SPLIT3   = 27'd1 << 6,
    S_SPLIT4   = 27'd1 << 7,
    S_USE      = 27'd1 << 8,
    S_APPEND   = 27'd1 << 9,
    S_APP2     = 27'd1 << 10,
    S_FWALK    = 27'd1 << 11,
    S_FW_NX    = 27'd1 << 12,
    S_RD_TGT   = 27'd1 << 13,
    S_TGT_CHK  = 27'd1 << 14,
    S_NXT_CHK  = 27'd1 << 15,
    S_NXT_TST  = 27'd1 << 16,
    S_JN1      = 27'd1 << 17,
    S_JN2      = 27'd1 << 18,
    S_PREV     = 27'd1 << 19,
    S_PREV_RD  = 27'd1 << 20,
    S_PREV_TST = 27'd1 << 21,
    S_JP1      = 27'd1 << 22,
    S_JP2      = 27'd1 << 23,
    S_FIN      = 27'd1 << 24,
    S_SPARE1   = 27'd1 << 25,
    S_SPARE2   = 27'd1 << 26
  } state_e;

  state_e  state_q, state_d;
  status_e code_q, code_d;
  logic    out_valid_q, out_valid_d;

  always_comb begin
    state_d      = state_q;
    code_d       = code_q;
    cmd_o.op       = OP_NONE;
    cmd_o.res_load = 1'b0;
    cmd_o.res_code = code_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.is_free_cmd) begin
          if (sts_i.addr_low) begin
            code_d = ST_IGNORED; state_d = S_FIN;
          end else begin
            state_d = S_FWALK;
          end
        end else if (sts_i.size_zero) begin
          code_d = ST_NO_SPACE; state_d = S_FIN;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.h_ge_brk) begin
          state_d = S_APPEND;
        end else begin
          cmd_o.op = OP_READ_H; state_d = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (sts_i.fit) begin
          state_d = sts_i.can_split ? S_SPLIT1 : S_USE;
        end else begin
          cmd_o.op = OP_NEXT; state_d = S_SCAN;
        end
      end
      S_SPLIT1: begin cmd_o.op = OP_SPLIT_W1; state_d = S_SPLIT2; end
      S_SPLIT2: begin cmd_o.op = OP_SPLIT_W2; state_d = S_SPLIT3; end
      S_SPLIT3: begin cmd_o.op = OP_SPLIT_W3; state_d = S_SPLIT4; end
      S_SPLIT4: begin
        cmd_o.op = OP_SPLIT_W4; code_d = ST_ALLOCATED; state_d = S_FIN;
      end
      S_USE: begin
        cmd_o.op = OP_USE_W; code_d = ST_ALLOCATED; state_d = S_FIN;
      end
      S_APPEND: begin
        if (sts_i.app_ok) begin
          cmd_o.op = OP_APP_W1; state_d = S_APP2;
        end else begin
          code_d = ST_NO_SPACE; state_d = S_FIN;
        end
      end
      S_APP2: begin
        cmd_o.op = OP_APP_W2; code_d = ST_ALLOCATED; state_d = S_FIN;
      end
      S_FWALK: begin
        if (sts_i.h_ge_brk || sts_i.h_gt_tgt) begin
          code_d = ST_IGNORED; state_d = S_FIN;
        end else if (sts_i.h_eq_tgt) begin
          state_d = S_RD_TGT;
        end else begin
          cmd_o.op = OP_READ_H; state_d = S_FW_NX;
        end
      end
      S_FW_NX:  begin cmd_o.op = OP_NEXT; state_d = S_FWALK; end
      S_RD_TGT: begin cmd_o.op = OP_READ_TGT; state_d = S_TGT_CHK; end
      S_TGT_CHK: begin
        if (sts_i.rd_free) begin
          code_d = ST_IGNORED; state_d = S_FIN;
        end else begin
          cmd_o.op = OP_FREE_W; state_d = S_NXT_CHK;
        end
      end
      S_NXT_CHK: begin
        if (sts_i.h_eq_brk) begin
          state_d = S_PREV;
        end else begin
          cmd_o.op = OP_READ_H; state_d = S_NXT_TST;
        end
      end
      S_NXT_TST: state_d = sts_i.rd_free ? S_JN1 : S_PREV;
      S_JN1:     begin cmd_o.op = OP_JN_W1; state_d = S_JN2; end
      S_JN2:     begin cmd_o.op = OP_JN_W2; state_d = S_PREV; end
      S_PREV: begin
        if (sts_i.tgt_zero) begin
          code_d = ST_FREED; state_d = S_FIN;
        end else begin
          cmd_o.op = OP_READ_PF; state_d = S_PREV_RD;
        end
      end
      S_PREV_RD: begin cmd_o.op = OP_READ_PREV; state_d = S_PREV_TST; end
      S_PREV_TST: begin
        if (sts_i.rd_free) begin
          state_d = S_JP1;
        end else begin
          code_d = ST_FREED; state_d = S_FIN;
        end
      end
      S_JP1: begin cmd_o.op = OP_JP_W1; state_d = S_JP2; end
      S_JP2: begin
        cmd_o.op = OP_JP_W2; code_d = ST_FREED; state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      code_q      <= ST_ALLOCATED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      code_q      <= code_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== test/boundary_tag_first_fit_allocator_unit_tb.sv =====
module boundary_tag_first_fit_allocator_unit_tb import bta_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // One request as the sender presents it.
  typedef struct {
    command_e    cmd;
    logic [12:0] size;
    logic [11:0] addr;
  } request_t;

  // One result as the receiver expects it.
  typedef struct {
    logic [11:0] addr;
    status_e     status;
  } answer_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [12:0] cfg_data_i;

  boundary_tag_first_fit_allocator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Shadow heap: one tag per 2-byte word, as the block keeps it.
  logic [12:0] shadow_tags [DEPTH];
  logic [12:0] shadow_break;
  logic [12:0] shadow_limit;

  request_t pending_requests[$];
  answer_t  expected_answers[$];
  int       mismatch_count;
  int       tx_gap;
  int       rx_gap;
  int       rx_hold;
  bit       stimulus_done;
  request_t tx_next;

  function automatic logic [12:0] tag_rd(logic [12:0] off);
    return shadow_tags[off[12:1] % DEPTH];
  endfunction

  function automatic void tag_wr(logic [12:0] off, logic [12:0] v);
    shadow_tags[off[12:1] % DEPTH] = v;
  endfunction

  function automatic logic [12:0] payload_at(logic [12:0] h);
    return tag_rd(h) & ~13'd1;
  endfunction

  function automatic logic [12:0] block_after(logic [12:0] h);
    return h + payload_at(h) + 13'd8;
  endfunction

  function automatic void lay_out(logic [12:0] h, logic [12:0] p, bit fr);
    tag_wr(h, p | 13'(fr));
    tag_wr(h + 13'd4 + p, h);
  endfunction

  function automatic void merge_forward(logic [12:0] h);
    logic [12:0] n;
    n = block_after(h);
    lay_out(h, payload_at(h) + payload_at(n) + 13'd8, 1'b1);
  endfunction

  // Works out the answer to one request and updates the shadow heap.
  function automatic answer_t allocator_answer(request_t r);
    answer_t     a;
    logic [13:0] sz;
    logic [12:0] lim;
    logic [12:0] h;
    logic [12:0] p;
    logic [12:0] tgt;
    logic [12:0] prv;
    logic [12:0] nb;
    logic [12:0] tg;
    bit          found;
    int          guard;
    a.addr = '0;
    if (r.cmd == CMD_ALLOC) begin
      lim = (shadow_limit > 13'd4096) ? 13'd4096 : shadow_limit;
      a.status = ST_NO_SPACE;
      if (r.size == 0) return a;
      sz = (14'(r.size) + 14'd1) & ~14'd1;
      h = 0;
      for (guard = 0; h < shadow_break && guard < DEPTH; guard++) begin
        p = payload_at(h);
        tg = tag_rd(h);
        if (tg[0] && 14'(p) >= sz) begin
          if (14'(p) - sz >= 14'd24) begin
            lay_out(h, 13'(sz), 1'b0);
            lay_out(h + 13'(sz) + 13'd8, p - 13'(sz) - 13'd8, 1'b1);
          end else begin
            lay_out(h, p, 1'b0);
          end
          a.addr = 12'(h + 13'd4);
          a.status = ST_ALLOCATED;
          return a;
        end
        h = block_after(h);
      end
      if (14'(shadow_break) + sz + 14'd8 <= 14'(lim)) begin
        h = shadow_break;
        lay_out(h, 13'(sz), 1'b0);
        shadow_break = h + 13'(sz) + 13'd8;
        a.addr = 12'(h + 13'd4);
        a.status = ST_ALLOCATED;
      end
      return a;
    end
    a.status = ST_IGNORED;
    if (r.addr < 4) return a;
    tgt = 13'(r.addr) - 13'd4;
    found = 0;
    h = 0;
    for (guard = 0; h < shadow_break && guard < DEPTH; guard++) begin
      if (h == tgt) begin
        found = 1;
        break;
      end
      if (h > tgt) break;
      h = block_after(h);
    end
    if (!found) return a;
    tg = tag_rd(tgt);
    if (tg[0]) return a;
    lay_out(tgt, payload_at(tgt), 1'b1);
    nb = block_after(tgt);
    tg = tag_rd(nb);
    if (nb != shadow_break && tg[0])
      merge_forward(tgt);
    if (tgt != 0) begin
      prv = tag_rd(tgt - 13'd4);
      tg = tag_rd(prv);
      if (tg[0]) merge_forward(prv);
    end
    a.status = ST_FREED;
    return a;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Sender: offers the head of the pending queue after a random gap and holds it
  // until it is taken. The stimulus process may pause it through tx_pause.
  bit tx_pause;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      tx_gap        <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_answers.push_back(allocator_answer(pending_requests.pop_front()));
        s_axis_tvalid <= 1'b0;
        tx_gap        <= $urandom_range(0, 9);
      end else if (s_axis_tvalid) begin
        // keep offering the same transaction
      end else if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
      end else if (!tx_pause && pending_requests.size() > 0) begin
        tx_next = pending_requests[0];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, tx_next.addr, tx_next.size};
        s_axis_tuser  <= tx_next.cmd;
      end
    end
  end

  // Receiver: random ready with occasional long hold-off, and the checker.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_gap        <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          answer_t e;
          e = expected_answers.pop_front();
          if (m_axis_tdata[11:0] != e.addr)
            report_mismatch($sformatf("address %0d, expected %0d", m_axis_tdata[11:0], e.addr));
          if (m_axis_tdata[15:12] != 0)
            report_mismatch("tdata padding not zero");
          if (m_axis_tuser != e.status)
            report_mismatch($sformatf("status %0d, expected %0d", m_axis_tuser, e.status));
        end
      end
      if (rx_hold > 0) begin
        m_axis_tready <= 1'b0;
      end else if (m_axis_tvalid && m_axis_tready) begin
        rx_gap <= $urandom_range(0, 9);
        m_axis_tready <= ($urandom_range(0, 2) == 0);
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off, counted in its own process.
  always @(posedge clk_i) begin
    if (rx_hold > 0) rx_hold <= rx_hold - 1;
  end

  task automatic queue_alloc(int sz);
    request_t r;
    r.cmd = CMD_ALLOC;
    r.size = 13'(sz);
    r.addr = 12'($urandom);
    pending_requests.push_back(r);
  endtask

  task automatic queue_free(int ad);
    request_t r;
    r.cmd = CMD_FREE;
    r.size = 13'($urandom);
    r.addr = 12'(ad);
    pending_requests.push_back(r);
  endtask

  // Waits until everything queued has been answered, then lets the unit settle.
  task automatic drain_all();
    wait (pending_requests.size() == 0 && !s_axis_tvalid && expected_answers.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_limit(int v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= 13'(v);
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_limit = 13'(v);
    cfg_valid_i <= 1'b0;
  endtask

  // A random phase: mostly plausible allocations and frees at even addresses,
  // plus some bad frees and odd sizes.
  task automatic random_phase(int n);
    int k;
    int sel;
    int idx;
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        queue_alloc(($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                                 : $urandom_range(1, 120));
      end else if (sel < 85 && expected_answers.size() == 0) begin
        // Even addresses spread over the heap, some of them block starts.
        queue_free(4 + 2 * $urandom_range(0, 2000));
      end else if (sel < 92) begin
        queue_free($urandom_range(0, 4095));
      end else begin
        queue_free($urandom_range(0, 3));
      end
    end
  endtask

  initial begin
    int k;
    int a;
    int ph;
    mismatch_count = 0;
    stimulus_done = 0;
    tx_pause = 0;
    rx_hold = 0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    for (k = 0; k < DEPTH; k++) shadow_tags[k] = '0;
    shadow_break = '0;
    shadow_limit = 13'd4096;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Directed: zero size, odd sizes, extremes, bad frees, merges, reuse with splits.
    queue_alloc(0);
    queue_alloc(1);          // payload 4..5, rounded to 2
    queue_alloc(15);
    queue_alloc(40);
    queue_alloc(2);
    queue_alloc(8191);       // far too large
    queue_alloc(4096);
    queue_free(0);           // below the tag size
    queue_free(3);
    queue_free(6);           // inside a block
    queue_free(14);          // second block
    queue_free(14);          // already free
    queue_free(4);           // merges with the free next block
    queue_free(38);          // third block, merges with the previous
    queue_alloc(10);         // reuses the merged free block, with a split
    queue_alloc(2);          // split from the remaining free block
    queue_free(4095);
    queue_alloc(4000);       // no space
    drain_all();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_limit(8);
        1: write_limit(8191);
        2: write_limit($urandom_range(64, 600));
        3: write_limit(4096);
        4: write_limit($urandom_range(8, 63));
        default: write_limit(4095);
      endcase
      if (ph == 2) begin
        // Hold the receiver off while the sender keeps offering.
        rx_hold = 300;
      end
      for (k = 0; k < 90; k++) begin
        if ($urandom_range(0, 1) && shadow_break > 0) begin
          wait (expected_answers.size() == 0 && pending_requests.size() == 0 && !s_axis_tvalid);
          a = 4;
          // pick a real block start half the time
          begin
            logic [12:0] h;
            int steps;
            steps = $urandom_range(0, 20);
            h = 0;
            while (steps > 0 && block_after(h) < shadow_break) begin
              h = block_after(h);
              steps--;
            end
            a = h + 4;
          end
          queue_free(($urandom_range(0, 9) == 0) ? a + 2 : a);
        end else begin
          random_phase(1);
        end
      end
      if (ph == 3) begin
        // Sender pauses until every expected result is in.
        tx_pause = 1;
        wait (expected_answers.size() == 0);
        tx_pause = 0;
      end
      drain_all();
    end
    stimulus_done = 1;
  end

  initial begin
    wait (stimulus_done);
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0 && expected_answers.size() == 0) begin
      $display("boundary_tag_first_fit_allocator_unit verification clean");
    end else begin
      $display("boundary_tag_first_fit_allocator_unit verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("boundary_tag_first_fit_allocator_unit verification failed");
    $finish;
  end

endmodule

// ===== boundary_tag_first_fit_allocator_unit.f =====
design/bta_pkg.sv
design/bta_dp.sv
design/bta_ctrl.sv
design/boundary_tag_first_fit_allocator_unit.sv
test/boundary_tag_first_fit_allocator_unit_tb.sv
